// ===== rtl/core/ffa_pkg.sv =====
// Package with constants and item types of the first-fit free-list allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;
  localparam int RegionBytes = 32768;
  localparam int HeaderBytes = 16;
  localparam int AlignBytes = 8;
  localparam int Words = RegionBytes / AlignBytes;
  localparam int WordW = $clog2(Words);
  localparam int PtrW = WordW + 1;
  localparam int HdrWords = HeaderBytes / AlignBytes;
  localparam int AlignW = $clog2(AlignBytes);

  localparam logic [PtrW-1:0] NIL = PtrW'(Words);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE = 2'd1,
    CMD_INIT = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_BAD_SIZE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [15:0] req_size;
    logic [14:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [14:0] payload_offset;
    logic [1:0] status;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/core/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list allocator with coalescing.
//
// channel  | signals                        | direction
// in       | in_valid, in_ready, in_item     | request item into the block
// out      | out_valid, out_ready, out_item  | result item out of the block
// cfg      | cfg_valid, cfg_ready, cfg_data  | region size register write
//
// An alloc visits each free block in S_ARD and S_ACHK, and a split adds S_FBLK.
// A failed alloc ends in S_ARD after its walk of the whole list.
// A free walks S_FCHK, S_FCUR, S_FCCK per lower free block; a bad offset ends in S_FRD.
// Init, destroy and a zero-size alloc answer at the accepting edge.
// Reset is synchronous; the memories are not cleared, only entry 0 is written as one block.
// One item is worked on at a time, and a result that is not taken holds off the next item.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_free_list_allocator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire ffa_pkg::in_item_t in_item,
  output logic out_valid,
  input  wire logic out_ready,
  output ffa_pkg::out_item_t out_item,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import ffa_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_ARD = 11'b00000000010,
    S_ACHK = 11'b00000000100,
    S_FRD = 11'b00000001000,
    S_FCHK = 11'b00000010000,
    S_FPRV = 11'b00000100000,
    S_FPCK = 11'b00001000000,
    S_FCUR = 11'b00010000000,
    S_FCCK = 11'b00100000000,
    S_FBLK = 11'b01000000000,
    S_FBCK = 11'b10000000000
  } state_t;

  logic [15:0] size_mem [Words];
  logic [PtrW-1:0] link_mem [Words];

  state_t state;
  logic [15:0] region_bytes;
  logic [16:0] pool_bytes;
  logic [PtrW-1:0] list_head;
  in_item_t item;
  logic [16:0] need;
  logic [PtrW-1:0] prev, cur, bw;
  logic [15:0] prev_size, bw_size;
  logic [PtrW:0] steps;
  logic [WordW-1:0] rd_addr;
  logic [15:0] rd_size;
  logic [PtrW-1:0] rd_link_raw, rd_link;
  logic res_pending;
  out_item_t res;

  logic we_s, we_l;
  logic [WordW-1:0] wa_s, wa_l;
  logic [15:0] wd_s;
  logic [PtrW-1:0] wd_l;

  always_ff @(posedge clk) begin
    if (we_s) size_mem[wa_s] <= wd_s;
    if (we_l) link_mem[wa_l] <= wd_l;
    rd_size <= size_mem[rd_addr];
    rd_link_raw <= link_mem[rd_addr];
  end
  assign rd_link = (rd_link_raw >= NIL) ? NIL : rd_link_raw;

  logic [16:0] init_b;
  always_comb begin
    init_b = {1'b0, region_bytes[15:AlignW], {AlignW{1'b0}}};
    if (init_b < 17'(HeaderBytes + 2 * AlignBytes)) init_b = 17'(HeaderBytes + 2 * AlignBytes);
    if (init_b > 17'(RegionBytes)) init_b = 17'(RegionBytes);
  end

  logic [15:0] rest;
  logic [WordW-1:0] split_w;
  logic [16:0] hb;
  logic [WordW-1:0] hb_w;
  logic [17:0] prev_end, bw_end;
  assign rest = rd_size - need[15:0];
  assign split_w = WordW'(cur) + WordW'(HdrWords) + WordW'(need >> AlignW);
  assign hb = {2'b00, item.block_offset} - 17'(HeaderBytes);
  assign hb_w = WordW'(hb >> AlignW);
  assign prev_end = 18'({prev[WordW-1:0], {AlignW{1'b0}}}) + 18'(prev_size) + 18'(HeaderBytes);
  assign bw_end = 18'({bw[WordW-1:0], {AlignW{1'b0}}}) + 18'(bw_size) + 18'(HeaderBytes);

  assign cfg_ready = (state == S_IDLE);
  assign in_ready = (state == S_IDLE) && !(res_pending && !out_ready);
  assign out_valid = res_pending;
  assign out_item = res;

  always_ff @(posedge clk) begin
    logic done;
    out_item_t done_res;
    done = 1'b0;
    done_res = '0;
    if (rst) begin
      state <= S_IDLE;
      res_pending <= 1'b0;
      region_bytes <= 16'(RegionBytes);
      pool_bytes <= 17'(RegionBytes);
      list_head <= '0;
      we_s <= 1'b1;
      wa_s <= '0;
      wd_s <= 16'(RegionBytes - HeaderBytes);
      we_l <= 1'b1;
      wa_l <= '0;
      wd_l <= NIL;
    end else begin
      we_s <= 1'b0;
      we_l <= 1'b0;
      if (res_pending && out_ready) res_pending <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) region_bytes <= cfg_data;
          if (in_valid && in_ready) begin
            item <= in_item;
            need <= (17'(in_item.req_size) + 17'(AlignBytes - 1)) & ~17'(AlignBytes - 1);
            prev <= NIL;
            cur <= (list_head >= NIL) ? NIL : list_head;
            steps <= '0;
            rd_addr <= list_head[WordW-1:0];
            unique case (in_item.cmd)
              CMD_ALLOC: begin
                if (in_item.req_size == 16'd0) begin
                  done = 1'b1;
                  done_res.status = ST_BAD_SIZE;
                end else state <= S_ARD;
              end
              CMD_FREE: state <= S_FRD;
              CMD_INIT: begin
                pool_bytes <= init_b;
                list_head <= '0;
                we_s <= 1'b1;
                wa_s <= '0;
                wd_s <= 16'(init_b - 17'(HeaderBytes));
                we_l <= 1'b1;
                wa_l <= '0;
                wd_l <= NIL;
                done = 1'b1;
              end
              CMD_DESTROY: begin
                pool_bytes <= '0;
                list_head <= NIL;
                done = 1'b1;
              end
            endcase
          end
        end
        S_ARD: begin
          if (cur == NIL || steps >= (PtrW+1)'(Words)) begin
            done = 1'b1;
            done_res.status = ST_NO_FIT;
            state <= S_IDLE;
          end else state <= S_ACHK;
        end
        S_ACHK: begin
          if ({1'b0, rd_size} >= need) begin
            if (rest >= 16'(HeaderBytes + AlignBytes)) begin
              we_s <= 1'b1;
              wa_s <= split_w;
              wd_s <= rest - 16'(HeaderBytes);
              we_l <= 1'b1;
              wa_l <= split_w;
              wd_l <= rd_link;
              if (prev == NIL) list_head <= {1'b0, split_w};
              state <= S_FBLK;
            end else begin
              if (prev == NIL) list_head <= rd_link;
              else begin
                we_l <= 1'b1;
                wa_l <= prev[WordW-1:0];
                wd_l <= rd_link;
              end
              done = 1'b1;
              done_res.payload_offset = 15'({cur[WordW-1:0], {AlignW{1'b0}}}) + 15'(HeaderBytes);
              state <= S_IDLE;
            end
          end else begin
            prev <= cur;
            cur <= rd_link;
            steps <= steps + 1'b1;
            rd_addr <= rd_link[WordW-1:0];
            state <= S_ARD;
          end
        end
        S_FBLK: begin
          // Second write of a split: shrink the taken block and relink prev.
          we_s <= 1'b1;
          wa_s <= cur[WordW-1:0];
          wd_s <= need[15:0];
          if (prev != NIL) begin
            we_l <= 1'b1;
            wa_l <= prev[WordW-1:0];
            wd_l <= {1'b0, split_w};
          end
          done = 1'b1;
          done_res.payload_offset = 15'({cur[WordW-1:0], {AlignW{1'b0}}}) + 15'(HeaderBytes);
          state <= S_IDLE;
        end
        S_FRD: begin
          if (item.block_offset < 15'(HeaderBytes) || hb[AlignW-1:0] != '0 ||
              hb >= pool_bytes) begin
            done = 1'b1;
            state <= S_IDLE;
          end else begin
            bw <= {1'b0, hb_w};
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (cur != NIL && cur < bw && steps < (PtrW+1)'(Words)) begin
            rd_addr <= cur[WordW-1:0];
            state <= S_FCUR;
          end else begin
            rd_addr <= bw[WordW-1:0];
            state <= S_FBCK;
          end
        end
        S_FCUR: state <= S_FCCK;
        S_FCCK: begin
          prev <= cur;
          prev_size <= rd_size;
          cur <= rd_link;
          steps <= steps + 1'b1;
          state <= S_FCHK;
        end
        S_FBCK: begin
          rd_addr <= cur[WordW-1:0];
          state <= S_FPRV;
        end
        S_FPRV: begin
          // rd_size holds the size of the freed block.
          if (prev != NIL && prev_end == 18'(hb)) begin
            bw_size <= prev_size + rd_size + 16'(HeaderBytes);
            bw <= prev;
            we_s <= 1'b1;
            wa_s <= prev[WordW-1:0];
            wd_s <= prev_size + rd_size + 16'(HeaderBytes);
          end else begin
            bw_size <= rd_size;
            if (prev == NIL) list_head <= bw;
            else begin
              we_l <= 1'b1;
              wa_l <= prev[WordW-1:0];
              wd_l <= bw;
            end
          end
          state <= S_FPCK;
        end
        S_FPCK: begin
          // rd_size and rd_link now belong to the next free block.
          if (cur != NIL && bw_end == 18'({cur[WordW-1:0], {AlignW{1'b0}}})) begin
            we_s <= 1'b1;
            wa_s <= bw[WordW-1:0];
            wd_s <= bw_size + rd_size + 16'(HeaderBytes);
            we_l <= 1'b1;
            wa_l <= bw[WordW-1:0];
            wd_l <= rd_link;
          end else if (bw[WordW-1:0] == hb_w) begin
            we_l <= 1'b1;
            wa_l <= bw[WordW-1:0];
            wd_l <= cur;
          end
          done = 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (done) begin
        res <= done_res;
        res_pending <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_no_in: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item))) else $error("result lost");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.status != 2'd3)) else $error("bad status");
`endif
endmodule
`default_nettype wire
